FILE: sv/assert_macros.svh
// Assertion macros shared by the command frame parser modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent
`define ACP_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("acp assertion failed");

// Consequent must hold in the cycle after the antecedent
`define ACP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("acp assertion failed");

`endif

FILE: sv/acp_pkg.sv
// Types and constants of the ASCII command frame parser
`timescale 1ns / 1ps
package acp_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned ValueW = 31;
  localparam int unsigned AccW   = 30;
  localparam int unsigned IdxW   = 4;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [ByteW-1:0] StartReset = 8'd64;
  localparam logic [ByteW-1:0] SepReset   = 8'd44;
  localparam logic [ByteW-1:0] EndReset   = 8'd101;

  localparam logic [ByteW-1:0] ChZero  = 8'd48;
  localparam logic [ByteW-1:0] ChNine  = 8'd57;
  localparam logic [ByteW-1:0] ChSpace = 8'd32;
  localparam logic [ByteW-1:0] ChTab   = 8'd9;
  localparam logic [ByteW-1:0] ChCr    = 8'd13;
  localparam logic [ByteW-1:0] ChMinus = 8'd45;
  localparam logic [ByteW-1:0] ChPlus  = 8'd43;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_START = 2'd0,
    CFG_SEP   = 2'd1,
    CFG_END   = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    PH_SKIP   = 2'd0,
    PH_DIGITS = 2'd1,
    PH_DONE   = 2'd2
  } conv_phase_t;

  typedef enum logic [1:0] {
    S_RECV = 2'b01,
    S_EMIT = 2'b10
  } ctl_state_t;

  typedef struct packed {
    logic byte_en;
    logic emit_adv;
    logic clear;
  } ctl_cmd_t;

  typedef struct packed {
    logic emit_last;
  } dp_status_t;

  typedef struct packed {
    logic                     frame_valid;
    logic                     is_action;
    logic [IdxW-1:0]          arg_index;
    logic signed [ValueW-1:0] field_value;
    logic                     truncated;
    logic                     last;
  } result_t;

endpackage

FILE: sv/acp_ifs.sv
// Byte and result channel interfaces of the command frame parser
`timescale 1ns / 1ps
interface acp_byte_if;
  logic                        valid;
  logic                        ready;
  logic [acp_pkg::ByteW-1:0]   rx_byte;
  logic                        chunk_end;

  modport source (output valid, output rx_byte, output chunk_end, input ready);
  modport sink (input valid, input rx_byte, input chunk_end, output ready);
endinterface

interface acp_result_if;
  logic                               valid;
  logic                               ready;
  logic                               frame_valid;
  logic                               is_action;
  logic [acp_pkg::IdxW-1:0]           arg_index;
  logic signed [acp_pkg::ValueW-1:0]  field_value;
  logic                               truncated;
  logic                               last;

  modport source (output valid, output frame_valid, output is_action, output arg_index,
                  output field_value, output truncated, output last, input ready);
  modport sink (input valid, input frame_valid, input is_action, input arg_index,
                input field_value, input truncated, input last, output ready);
endinterface

FILE: sv/acp_datapath.sv
// Datapath: delimiter registers, field conversion, argument store, result mux
`timescale 1ns / 1ps
`include "assert_macros.svh"
module acp_datapath #(
  parameter int unsigned MAX_ARGS        = 4,
  parameter int unsigned MAX_FIELD_CHARS = 9
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [acp_pkg::CfgIdxW-1:0]       cfg_index,
  input  logic [acp_pkg::ByteW-1:0]         cfg_data,
  input  logic [acp_pkg::ByteW-1:0]         rx_byte,
  input  acp_pkg::ctl_cmd_t                 cmd,
  output acp_pkg::dp_status_t               status,
  output acp_pkg::result_t                  result
);

  localparam int unsigned CntW = $clog2(MAX_ARGS + 1);
  localparam int unsigned AddrW = (MAX_ARGS > 1) ? $clog2(MAX_ARGS) : 1;

  logic [acp_pkg::ByteW-1:0] start_byte;
  logic [acp_pkg::ByteW-1:0] separator_byte;
  logic [acp_pkg::ByteW-1:0] end_byte;

  logic                             at_chunk_start;
  logic                             first_was_start;
  logic                             end_reached;
  logic                             prev_byte_was_end;
  logic                             action_done;
  logic signed [acp_pkg::ValueW-1:0] action_value;
  logic signed [acp_pkg::ValueW-1:0] arg_store [MAX_ARGS];
  logic [CntW-1:0]                  arg_count;
  logic [acp_pkg::AccW-1:0]         accumulator;
  logic                             negative_sign;
  acp_pkg::conv_phase_t             conversion_phase;
  logic [3:0]                       field_char_count;
  logic                             overflow_seen;
  logic [CntW-1:0]                  emit_idx;

  logic                             is_start, is_sep, is_end;
  logic                             take, fin, feed, feed_over;
  logic                             c_digit, c_ws, c_sign, run_digits;
  logic [acp_pkg::AccW-1:0]         accumulator_next;
  logic                             negative_sign_next;
  acp_pkg::conv_phase_t             conversion_phase_next;
  logic signed [acp_pkg::ValueW-1:0] fin_value;
  logic                             args_full;
  logic [CntW-1:0]                  arg_pos;
  logic                             frame_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_byte     <= acp_pkg::StartReset;
      separator_byte <= acp_pkg::SepReset;
      end_byte       <= acp_pkg::EndReset;
    end else if (cfg_we) begin
      unique case (cfg_index)
        acp_pkg::CFG_START: start_byte     <= cfg_data;
        acp_pkg::CFG_SEP:   separator_byte <= cfg_data;
        acp_pkg::CFG_END:   end_byte       <= cfg_data;
        default: ;
      endcase
    end
  end

  assign is_start  = (rx_byte == start_byte);
  assign is_sep    = (rx_byte == separator_byte);
  assign is_end    = (rx_byte == end_byte);
  assign take      = !end_reached && !is_start;
  assign fin       = take && (is_sep || is_end);
  assign feed      = take && !is_sep && !is_end;
  assign feed_over = (field_char_count >= 4'(MAX_FIELD_CHARS));
  assign args_full = (arg_count >= CntW'(MAX_ARGS));

  assign c_digit = (rx_byte >= acp_pkg::ChZero) && (rx_byte <= acp_pkg::ChNine);
  assign c_ws    = (rx_byte == acp_pkg::ChSpace) ||
                   ((rx_byte >= acp_pkg::ChTab) && (rx_byte <= acp_pkg::ChCr));
  assign c_sign  = (rx_byte == acp_pkg::ChMinus) || (rx_byte == acp_pkg::ChPlus);

  always_comb begin
    conversion_phase_next = conversion_phase;
    accumulator_next      = accumulator;
    negative_sign_next    = negative_sign;
    run_digits            = 1'b0;
    unique case (conversion_phase)
      acp_pkg::PH_SKIP: begin
        if (c_ws) begin
          conversion_phase_next = conversion_phase;
        end else if (c_sign) begin
          negative_sign_next    = (rx_byte == acp_pkg::ChMinus);
          conversion_phase_next = acp_pkg::PH_DIGITS;
        end else begin
          run_digits = 1'b1;
        end
      end
      acp_pkg::PH_DIGITS: run_digits = 1'b1;
      default: ;
    endcase
    if (run_digits) begin
      if (c_digit) begin
        accumulator_next = (accumulator << 3) + (accumulator << 1)
                         + acp_pkg::AccW'(rx_byte - acp_pkg::ChZero);
        conversion_phase_next = acp_pkg::PH_DIGITS;
      end else begin
        conversion_phase_next = acp_pkg::PH_DONE;
      end
    end
  end

  assign fin_value = negative_sign ? (acp_pkg::ValueW'(0) - {1'b0, accumulator})
                                   : {1'b0, accumulator};

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      at_chunk_start    <= 1'b1;
      first_was_start   <= 1'b0;
      end_reached       <= 1'b0;
      prev_byte_was_end <= 1'b0;
      action_done       <= 1'b0;
      action_value      <= '0;
      arg_count         <= '0;
      accumulator       <= '0;
      negative_sign     <= 1'b0;
      conversion_phase  <= acp_pkg::PH_SKIP;
      field_char_count  <= '0;
      overflow_seen     <= 1'b0;
      emit_idx          <= '0;
    end else if (cmd.byte_en) begin
      if (at_chunk_start) begin
        first_was_start <= is_start;
        at_chunk_start  <= 1'b0;
      end
      prev_byte_was_end <= is_end;
      if (fin) begin
        if (!action_done) begin
          action_value <= fin_value;
          action_done  <= 1'b1;
        end else if (!args_full) begin
          arg_count <= arg_count + 1'b1;
        end else begin
          overflow_seen <= 1'b1;
        end
        accumulator      <= '0;
        negative_sign    <= 1'b0;
        conversion_phase <= acp_pkg::PH_SKIP;
        field_char_count <= '0;
        if (is_end && !is_sep) begin
          end_reached <= 1'b1;
        end
      end else if (feed) begin
        if (feed_over) begin
          overflow_seen <= 1'b1;
        end else begin
          field_char_count <= field_char_count + 1'b1;
          accumulator      <= accumulator_next;
          negative_sign    <= negative_sign_next;
          conversion_phase <= conversion_phase_next;
        end
      end
    end else if (cmd.emit_adv) begin
      emit_idx <= emit_idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.byte_en && fin && action_done && !args_full) begin
      arg_store[arg_count[AddrW-1:0]] <= fin_value;
    end
  end

  assign frame_ok = first_was_start && prev_byte_was_end;
  assign arg_pos  = emit_idx - 1'b1;

  assign status.emit_last = !frame_ok || (emit_idx == arg_count);

  always_comb begin
    result.frame_valid = frame_ok;
    result.is_action   = (emit_idx == '0);
    result.arg_index   = (emit_idx == '0) ? '0 : 4'(arg_pos);
    result.truncated   = frame_ok && overflow_seen;
    result.last        = status.emit_last;
    if (!frame_ok) begin
      result.field_value = '0;
    end else if (emit_idx == '0) begin
      result.field_value = action_value;
    end else begin
      result.field_value = arg_store[arg_pos[AddrW-1:0]];
    end
  end

  `ACP_ASSERT_SAME(a_emit_in_range, cmd.emit_adv, emit_idx < arg_count)
  `ACP_ASSERT_NEXT(a_end_latched, cmd.byte_en && fin && !is_sep, end_reached)

endmodule

FILE: sv/acp_ctrl.sv
// Controller: receive and emit sequencing of the command frame parser
`timescale 1ns / 1ps
`include "assert_macros.svh"
module acp_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                rx_valid,
  input  logic                rx_chunk_end,
  output logic                rx_ready,
  output logic                res_valid,
  input  logic                res_ready,
  input  acp_pkg::dp_status_t status,
  output acp_pkg::ctl_cmd_t   cmd
);

  acp_pkg::ctl_state_t state, state_next;
  logic rx_beat, res_beat;

  assign rx_ready  = (state == acp_pkg::S_RECV);
  assign res_valid = (state == acp_pkg::S_EMIT);
  assign rx_beat   = rx_valid && rx_ready;
  assign res_beat  = res_valid && res_ready;

  assign cmd.byte_en  = rx_beat;
  assign cmd.emit_adv = res_beat && !status.emit_last;
  assign cmd.clear    = res_beat && status.emit_last;

  always_comb begin
    state_next = state;
    unique case (state)
      acp_pkg::S_RECV: if (rx_beat && rx_chunk_end) state_next = acp_pkg::S_EMIT;
      acp_pkg::S_EMIT: if (res_beat && status.emit_last) state_next = acp_pkg::S_RECV;
      default:         state_next = acp_pkg::S_RECV;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= acp_pkg::S_RECV;
    end else begin
      state <= state_next;
    end
  end

  `ACP_ASSERT_SAME(a_one_side, 1'b1, !(rx_ready && res_valid))
  `ACP_ASSERT_NEXT(a_chunk_emits, rx_beat && rx_chunk_end, res_valid)
  `ACP_ASSERT_NEXT(a_last_returns, res_beat && status.emit_last, rx_ready)

endmodule

FILE: sv/ascii_command_frame_parser_top.sv
// Top level of the ASCII command frame parser
`timescale 1ns / 1ps
// Takes one received byte per cycle while rx.ready is high. A byte flagged
// chunk_end closes the chunk; rx.ready then drops and the result run goes out
// on res: one beat for an invalid chunk, else the action and up to MAX_ARGS
// arguments, one beat per cycle while res.ready is high, with last on the final
// beat. The arguments of the run of 1 to MAX_ARGS+1 beats are read from the
// argument register file through its single read port; the action comes from
// its own register. Delimiter registers are written on cfg_we; write them
// only while the block is idle. No clearing pass after reset.
module ascii_command_frame_parser_top #(
  parameter int unsigned MAX_ARGS        = 4,
  parameter int unsigned MAX_FIELD_CHARS = 9
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [acp_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [acp_pkg::ByteW-1:0]   cfg_data,
  acp_byte_if.sink                    rx,
  acp_result_if.source                res
);

  acp_pkg::ctl_cmd_t   cmd;
  acp_pkg::dp_status_t status;
  acp_pkg::result_t    result;

  acp_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .rx_valid     (rx.valid),
    .rx_chunk_end (rx.chunk_end),
    .rx_ready     (rx.ready),
    .res_valid    (res.valid),
    .res_ready    (res.ready),
    .status       (status),
    .cmd          (cmd)
  );

  acp_datapath #(
    .MAX_ARGS        (MAX_ARGS),
    .MAX_FIELD_CHARS (MAX_FIELD_CHARS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .rx_byte   (rx.rx_byte),
    .cmd       (cmd),
    .status    (status),
    .result    (result)
  );

  assign res.frame_valid = result.frame_valid;
  assign res.is_action   = result.is_action;
  assign res.arg_index   = result.arg_index;
  assign res.field_value = result.field_value;
  assign res.truncated   = result.truncated;
  assign res.last        = result.last;

endmodule
